>>> hdl/faru_pkg.sv
// faru_pkg: shared types and constants for the fixed-point arithmetic unit.
// No dependencies; used by all files under hdl/.
package faru_pkg;

    localparam int DEF_WIDTH  = 32;
    localparam int FRAC_W     = 5;
    localparam int FRAC_MAX   = 31;
    localparam logic [FRAC_W-1:0] DEF_FRAC = 5'd16;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    // side info carried beside the divider data
    typedef struct packed {
        t_kind kind;
        logic  q_neg;
        logic  a_neg;
        logic  b_zero;
    } t_ctl;

endpackage

>>> hdl/fixed_point_arith_unit_core.sv
// fixed_point_arith_unit_core: pipelined signed Q-format add/sub/mul/div unit.
// Depends on faru_pkg, faru_prep, faru_div_step.
//
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  request  | i_valid o_ready i_kind i_operand_a/b       | in
//  result   | o_valid i_ready o_result                   | out
//  config   | i_cfg_valid o_cfg_ready i_cfg_frac_bits    | in
//
// Every request takes the same path, whatever its kind: three front stages, WIDTH+31 divider
// steps (one quotient bit per stage) and an output register. One request per
// cycle unless the pipeline is full and the result stalls.
// Reset (synchronous, active low) clears all valid bits and sets frac_bits to 16.
// Each stage holds only while it is full and the stage after it is held, so
// bubbles close up and a stalled result does not block the input until the
// pipeline is full. Requests carry their own copy of frac_bits.
module fixed_point_arith_unit_core #(
    parameter int WIDTH = faru_pkg::DEF_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [faru_pkg::FRAC_W-1:0] i_cfg_frac_bits
);
    // dividend magnitude |a| * 2^f needs up to WIDTH+31 bits
    localparam int DW = WIDTH + faru_pkg::FRAC_MAX;

    logic [faru_pkg::FRAC_W-1:0] r_frac;

    // chain between stages: index 0 is the front end output
    logic                 s_v   [0:DW];
    logic                 s_rdy [0:DW];
    faru_pkg::t_ctl       s_ctl [0:DW];
    logic [WIDTH-1:0]     s_res [0:DW];
    logic [DW-1:0]        s_dd  [0:DW];
    logic [WIDTH-1:0]     s_rem [0:DW];
    logic [WIDTH-1:0]     s_d   [0:DW];

    logic                    r_out_v;
    logic signed [WIDTH-1:0] r_out;
    logic [WIDTH-1:0]        n_q;
    logic signed [WIDTH-1:0] n_sel;
    logic                    out_rdy;

    // config register; always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= faru_pkg::DEF_FRAC;
        end else if (i_cfg_valid) begin
            r_frac <= i_cfg_frac_bits;
        end
    end

    faru_prep #(.WIDTH(WIDTH), .DW(DW)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_frac      (r_frac),
        .o_valid     (s_v[0]),
        .i_ready     (s_rdy[0]),
        .o_ctl       (s_ctl[0]),
        .o_res       (s_res[0]),
        .o_dd        (s_dd[0]),
        .o_d         (s_d[0])
    );
    assign s_rem[0] = '0;

    for (genvar g = 0; g < DW; g++) begin : g_div
        faru_div_step #(.WIDTH(WIDTH), .DW(DW)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_v[g]),
            .o_ready (s_rdy[g]),
            .i_ctl   (s_ctl[g]),
            .i_res   (s_res[g]),
            .i_dd    (s_dd[g]),
            .i_rem   (s_rem[g]),
            .i_d     (s_d[g]),
            .o_valid (s_v[g+1]),
            .i_ready (s_rdy[g+1]),
            .o_ctl   (s_ctl[g+1]),
            .o_res   (s_res[g+1]),
            .o_dd    (s_dd[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_d     (s_d[g+1])
        );
    end

    // final select: quotient sign fix, zero-divisor saturation
    assign out_rdy   = !r_out_v || i_ready;
    assign s_rdy[DW] = out_rdy;
    assign n_q       = s_dd[DW][WIDTH-1:0];

    always_comb begin
        n_sel = $signed(s_res[DW]);
        if (s_ctl[DW].kind == faru_pkg::KIND_DIV) begin
            if (s_ctl[DW].b_zero) begin
                n_sel = s_ctl[DW].a_neg ? {1'b1, {(WIDTH-1){1'b0}}}
                                        : {1'b0, {(WIDTH-1){1'b1}}};
            end else begin
                n_sel = s_ctl[DW].q_neg ? $signed(-n_q) : $signed(n_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_rdy) begin
            r_out_v <= s_v[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out <= n_sel;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = 32'(r_out);

    // input can only be held off when every stage is full and the result stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input held off without a stalled result");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // a held result stays unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");

endmodule

>>> hdl/faru_prep.sv
// faru_prep: three front stages (operand capture, multiply/add, product scaling).
// Depends on faru_pkg.
module faru_prep #(
    parameter int WIDTH = faru_pkg::DEF_WIDTH,
    parameter int DW    = WIDTH + faru_pkg::FRAC_MAX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_kind,
    input  logic [31:0]                i_operand_a,
    input  logic [31:0]                i_operand_b,
    input  logic [faru_pkg::FRAC_W-1:0] i_frac,
    output logic                       o_valid,
    input  logic                       i_ready,
    output faru_pkg::t_ctl             o_ctl,
    output logic [WIDTH-1:0]           o_res,
    output logic [DW-1:0]              o_dd,
    output logic [WIDTH-1:0]           o_d
);
    localparam int PW = 2 * WIDTH + 32;

    logic rdy1, rdy2, rdy3;
    logic r_v1, r_v2, r_v3;

    // stage 1
    logic signed [WIDTH-1:0]     r_a1, r_b1;
    faru_pkg::t_kind             r_k1;
    logic [faru_pkg::FRAC_W-1:0] r_f1;

    // stage 2
    logic signed [2*WIDTH-1:0]   r_prod2;
    logic [WIDTH-1:0]            r_res2;
    logic [DW-1:0]               r_dd2;
    logic [WIDTH-1:0]            r_d2;
    faru_pkg::t_ctl              r_ctl2;
    logic [faru_pkg::FRAC_W-1:0] r_f2;

    // stage 3
    faru_pkg::t_ctl              r_ctl3;
    logic [WIDTH-1:0]            r_res3;
    logic [DW-1:0]               r_dd3;
    logic [WIDTH-1:0]            r_d3;

    logic [WIDTH-1:0]     n_amag, n_bmag;
    logic signed [PW-1:0] n_pext, n_bias, n_scaled;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_ctl   = r_ctl3;
    assign o_res   = r_res3;
    assign o_dd    = r_dd3;
    assign o_d     = r_d3;

    assign n_amag = r_a1[WIDTH-1] ? WIDTH'(-r_a1) : WIDTH'(r_a1);
    assign n_bmag = r_b1[WIDTH-1] ? WIDTH'(-r_b1) : WIDTH'(r_b1);

    // truncate toward zero: bias negative products by 2^f - 1 before shifting
    assign n_pext   = PW'(r_prod2);
    assign n_bias   = r_prod2[2*WIDTH-1] ? ((PW'(1) << r_f2) - PW'(1)) : '0;
    assign n_scaled = (n_pext + n_bias) >>> r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_a1 <= $signed(i_operand_a[WIDTH-1:0]);
            r_b1 <= $signed(i_operand_b[WIDTH-1:0]);
            r_k1 <= faru_pkg::t_kind'(i_kind);
            r_f1 <= i_frac;
        end
        if (rdy2) begin
            r_prod2       <= r_a1 * r_b1;
            r_res2        <= (r_k1 == faru_pkg::KIND_SUB) ? WIDTH'(r_a1 - r_b1)
                                                          : WIDTH'(r_a1 + r_b1);
            r_dd2         <= DW'(n_amag) << r_f1;
            r_d2          <= n_bmag;
            r_ctl2.kind   <= r_k1;
            r_ctl2.q_neg  <= r_a1[WIDTH-1] ^ r_b1[WIDTH-1];
            r_ctl2.a_neg  <= r_a1[WIDTH-1];
            r_ctl2.b_zero <= (r_b1 == '0);
            r_f2          <= r_f1;
        end
        if (rdy3) begin
            r_ctl3 <= r_ctl2;
            r_res3 <= (r_ctl2.kind == faru_pkg::KIND_MUL) ? n_scaled[WIDTH-1:0] : r_res2;
            r_dd3  <= r_dd2;
            r_d3   <= r_d2;
        end
    end

endmodule

>>> hdl/faru_div_step.sv
// faru_div_step: one registered restoring-division step (one quotient bit).
// Depends on faru_pkg.
module faru_div_step #(
    parameter int WIDTH = faru_pkg::DEF_WIDTH,
    parameter int DW    = WIDTH + faru_pkg::FRAC_MAX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  faru_pkg::t_ctl     i_ctl,
    input  logic [WIDTH-1:0]   i_res,
    input  logic [DW-1:0]      i_dd,
    input  logic [WIDTH-1:0]   i_rem,
    input  logic [WIDTH-1:0]   i_d,
    output logic               o_valid,
    input  logic               i_ready,
    output faru_pkg::t_ctl     o_ctl,
    output logic [WIDTH-1:0]   o_res,
    output logic [DW-1:0]      o_dd,
    output logic [WIDTH-1:0]   o_rem,
    output logic [WIDTH-1:0]   o_d
);
    logic             r_v;
    faru_pkg::t_ctl   r_ctl;
    logic [WIDTH-1:0] r_res, r_rem, r_d;
    logic [DW-1:0]    r_dd;
    logic [WIDTH:0]   n_t, n_diff;
    logic             n_ge;

    assign o_ready = !r_v || i_ready;
    assign n_t     = {i_rem, i_dd[DW-1]};
    assign n_diff  = n_t - {1'b0, i_d};
    assign n_ge    = (n_t >= {1'b0, i_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ctl <= i_ctl;
            r_res <= i_res;
            r_d   <= i_d;
            r_rem <= n_ge ? n_diff[WIDTH-1:0] : n_t[WIDTH-1:0];
            r_dd  <= {i_dd[DW-2:0], n_ge};
        end
    end

    assign o_valid = r_v;
    assign o_ctl   = r_ctl;
    assign o_res   = r_res;
    assign o_dd    = r_dd;
    assign o_rem   = r_rem;
    assign o_d     = r_d;

endmodule
